### src/rep_pkg.sv
// Shared types and constants for the rectangle edge proximity classifier.
// No dependencies; imported by rep_offset, rep_square and the top level.
`timescale 1ns / 1ps

package rep_pkg;

  // Distance limit register
  localparam int unsigned LIMIT_BITS  = 10;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 10'd5;

  // Squared clamped offsets
  localparam int unsigned SQ_BITS  = 2 * LIMIT_BITS;
  localparam int unsigned SUM_BITS = SQ_BITS + 1;

  localparam int unsigned NUM_EDGES = 4;

  // Edge bits of the result code
  localparam int unsigned EDGE_XMIN = 0;
  localparam int unsigned EDGE_YMIN = 1;
  localparam int unsigned EDGE_YMAX = 2;
  localparam int unsigned EDGE_XMAX = 3;

  // Span axis of the along offsets
  localparam int unsigned AXIS_X = 0;
  localparam int unsigned AXIS_Y = 1;

  // Edges that span in y (vertical edges) use the y along offset
  localparam logic [NUM_EDGES-1:0] EDGE_ALONG_Y = 4'b1001;

  typedef logic [LIMIT_BITS-1:0] lim_t;

  // Clamped offsets leaving the offset unit
  typedef struct packed {
    logic [NUM_EDGES-1:0]        perp_over;
    lim_t [NUM_EDGES-1:0]        perp;
    logic [1:0]                  along_over;
    lim_t [1:0]                  along;
  } rep_off_t;

  // Stage load enables for a two-stage unit
  typedef struct packed {
    logic en_a;
    logic en_b;
  } rep_stage_en_t;

endpackage

### src/rep_offset.sv
// Offset unit: stages 1 and 2, perpendicular and along offsets, clamped to the limit.
// Depends on rep_pkg.
`timescale 1ns / 1ps

module rep_offset #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  rep_pkg::rep_stage_en_t       en,
  input  rep_pkg::lim_t                lim,
  input  logic signed [COORD_BITS-1:0] rect_x_min,
  input  logic signed [COORD_BITS-1:0] rect_y_min,
  input  logic signed [COORD_BITS-1:0] rect_x_max,
  input  logic signed [COORD_BITS-1:0] rect_y_max,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  output rep_pkg::rep_off_t            off
);
  import rep_pkg::*;

  localparam int unsigned CMP_W = (COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS;

  typedef logic [COORD_BITS-1:0] mag_t;

  // |a - b| always fits in COORD_BITS unsigned bits
  function automatic mag_t abs_diff(input logic signed [COORD_BITS-1:0] a,
                                    input logic signed [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] d;
    logic signed [COORD_BITS:0] m;
    d = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
    m = d[COORD_BITS] ? -d : d;
    return m[COORD_BITS-1:0];
  endfunction

  // Stage 1 registers
  mag_t [NUM_EDGES-1:0]         perp_abs;
  logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y, qx, qy;

  // Stage 1: perpendicular distances, ordered spans
  always_ff @(posedge clk) begin
    if (en.en_a) begin
      perp_abs[EDGE_XMIN] <= abs_diff(point_x, rect_x_min);
      perp_abs[EDGE_YMIN] <= abs_diff(point_y, rect_y_min);
      perp_abs[EDGE_YMAX] <= abs_diff(point_y, rect_y_max);
      perp_abs[EDGE_XMAX] <= abs_diff(point_x, rect_x_max);
      lo_x <= (rect_x_min <= rect_x_max) ? rect_x_min : rect_x_max;
      hi_x <= (rect_x_min <= rect_x_max) ? rect_x_max : rect_x_min;
      lo_y <= (rect_y_min <= rect_y_max) ? rect_y_min : rect_y_max;
      hi_y <= (rect_y_min <= rect_y_max) ? rect_y_max : rect_y_min;
      qx   <= point_x;
      qy   <= point_y;
    end
  end

  // Stage 2: distance beyond the span (zero inside)
  mag_t along_x, along_y;

  always_comb begin
    if (qx < lo_x) begin
      along_x = abs_diff(lo_x, qx);
    end else if (qx > hi_x) begin
      along_x = abs_diff(qx, hi_x);
    end else begin
      along_x = '0;
    end
    if (qy < lo_y) begin
      along_y = abs_diff(lo_y, qy);
    end else if (qy > hi_y) begin
      along_y = abs_diff(qy, hi_y);
    end else begin
      along_y = '0;
    end
  end

  // Clamp: anything above the limit only needs an over flag
  rep_off_t off_next;

  always_comb begin
    logic [CMP_W-1:0] lim_w;
    logic [CMP_W-1:0] v;
    lim_w = CMP_W'(lim);
    for (int i = 0; i < NUM_EDGES; i++) begin
      v = CMP_W'(perp_abs[i]);
      off_next.perp_over[i] = v > lim_w;
      off_next.perp[i]      = LIMIT_BITS'(v);
    end
    v = CMP_W'(along_x);
    off_next.along_over[AXIS_X] = v > lim_w;
    off_next.along[AXIS_X]      = LIMIT_BITS'(v);
    v = CMP_W'(along_y);
    off_next.along_over[AXIS_Y] = v > lim_w;
    off_next.along[AXIS_Y]      = LIMIT_BITS'(v);
  end

  always_ff @(posedge clk) begin
    if (en.en_b) begin
      off <= off_next;
    end
  end

endmodule

### src/rep_square.sv
// Square-and-compare unit: stages 3 and 4, squares of clamped offsets, limit test.
// Depends on rep_pkg.
`timescale 1ns / 1ps

module rep_square (
  input  logic                     clk,
  input  rep_pkg::rep_stage_en_t   en,
  input  rep_pkg::lim_t            lim,
  input  rep_pkg::rep_off_t        off,
  output logic [rep_pkg::NUM_EDGES-1:0] edge_code
);
  import rep_pkg::*;

  typedef logic [SQ_BITS-1:0] sq_t;

  // Stage 3 registers
  sq_t [NUM_EDGES-1:0] perp_sq;
  sq_t [1:0]           along_sq;
  sq_t                 lim_sq;
  logic [NUM_EDGES-1:0] in_box;

  // Stage 3: one 10x10 multiply per offset
  always_ff @(posedge clk) begin
    if (en.en_a) begin
      for (int i = 0; i < NUM_EDGES; i++) begin
        perp_sq[i] <= SQ_BITS'(off.perp[i]) * SQ_BITS'(off.perp[i]);
        in_box[i]  <= !off.perp_over[i] &&
                      !(EDGE_ALONG_Y[i] ? off.along_over[AXIS_Y] : off.along_over[AXIS_X]);
      end
      along_sq[AXIS_X] <= SQ_BITS'(off.along[AXIS_X]) * SQ_BITS'(off.along[AXIS_X]);
      along_sq[AXIS_Y] <= SQ_BITS'(off.along[AXIS_Y]) * SQ_BITS'(off.along[AXIS_Y]);
      lim_sq           <= SQ_BITS'(lim) * SQ_BITS'(lim);
    end
  end

  // Stage 4: perp^2 + along^2 <= limit^2, for offsets with no over flag
  logic [NUM_EDGES-1:0] code_next;

  always_comb begin
    logic [SUM_BITS-1:0] sum;
    for (int i = 0; i < NUM_EDGES; i++) begin
      sum = SUM_BITS'(perp_sq[i]) +
            SUM_BITS'(EDGE_ALONG_Y[i] ? along_sq[AXIS_Y] : along_sq[AXIS_X]);
      code_next[i] = in_box[i] && (sum <= SUM_BITS'(lim_sq));
    end
  end

  always_ff @(posedge clk) begin
    if (en.en_b) begin
      edge_code <= code_next;
    end
  end

endmodule

### src/rect_edge_proximity_classifier.sv
// Top level of the rectangle edge proximity classifier: handshake, limit register.
// Depends on rep_pkg, rep_offset and rep_square.
`timescale 1ns / 1ps

// Usage
//   Input stream s_*: one word per query, a rectangle (two corners) and a
//   point, six signed COORD_BITS fields packed from the low bit up.
//   Output stream m_*: one word per query, edge_code in m_tdata[3:0]
//   (bit0 xmin edge, bit1 ymin, bit2 ymax, bit3 xmax within the limit).
//   cfg_wen/cfg_wdata write the 10-bit distance limit (reset value 5);
//   write it only while no word is in flight.
// Timing
//   Four register stages: ordered spans and perpendicular offsets, along
//   offsets with clamping, squares, sum and compare. m_tvalid is the valid
//   bit of the last stage. While m_tready stays high, one word per cycle is
//   accepted and delivered sustained, kept by the per-stage valid bits.
// Reset and stall
//   rst (synchronous) empties the pipe and restores the limit. When the
//   receiver holds m_tready low, words pack into empty stages; s_tready
//   drops only once all four stages are full. Nothing is lost or repeated.
module rect_edge_proximity_classifier #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  // s_tdata, low bit up: rect_x_min, rect_y_min, rect_x_max, rect_y_max,
  // point_x, point_y (COORD_BITS each, signed), zero fill to bytes
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
  input  logic s_tvalid,
  output logic s_tready,
  // m_tdata, low bit up: edge_code (4 bits), zero fill
  output logic [7:0] m_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  input  logic cfg_wen,
  input  logic [rep_pkg::LIMIT_BITS-1:0] cfg_wdata
);
  import rep_pkg::*;

  localparam int unsigned STAGES = 4;

  // Distance limit register
  lim_t lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= LIMIT_RESET;
    end else if (cfg_wen) begin
      lim <= cfg_wdata;
    end
  end

  // Per-stage valid bits; a stage loads when empty or when it drains
  logic [STAGES-1:0] vld;
  logic [STAGES:0]   en;

  always_comb begin
    en[STAGES] = m_tready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[STAGES-1];

  // Unpack input word
  logic signed [COORD_BITS-1:0] rect_x_min, rect_y_min, rect_x_max, rect_y_max;
  logic signed [COORD_BITS-1:0] point_x, point_y;

  assign rect_x_min = s_tdata[0*COORD_BITS +: COORD_BITS];
  assign rect_y_min = s_tdata[1*COORD_BITS +: COORD_BITS];
  assign rect_x_max = s_tdata[2*COORD_BITS +: COORD_BITS];
  assign rect_y_max = s_tdata[3*COORD_BITS +: COORD_BITS];
  assign point_x    = s_tdata[4*COORD_BITS +: COORD_BITS];
  assign point_y    = s_tdata[5*COORD_BITS +: COORD_BITS];

  rep_stage_en_t en_off, en_sq;
  rep_off_t      off;
  logic [NUM_EDGES-1:0] edge_code;

  assign en_off = '{en_a: en[0] && s_tvalid, en_b: en[1] && vld[0]};
  assign en_sq  = '{en_a: en[2] && vld[1], en_b: en[3] && vld[2]};

  rep_offset #(
    .COORD_BITS (COORD_BITS)
  ) u_offset (
    .clk        (clk),
    .en         (en_off),
    .lim        (lim),
    .rect_x_min (rect_x_min),
    .rect_y_min (rect_y_min),
    .rect_x_max (rect_x_max),
    .rect_y_max (rect_y_max),
    .point_x    (point_x),
    .point_y    (point_y),
    .off        (off)
  );

  rep_square u_square (
    .clk       (clk),
    .en        (en_sq),
    .lim       (lim),
    .off       (off),
    .edge_code (edge_code)
  );

  assign m_tdata = {{(8-NUM_EDGES){1'b0}}, edge_code};

`ifndef SYNTHESIS
  // Full pipe with a stalled receiver must back-pressure the input
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (&vld && !m_tready) |-> !s_tready)
    else $error("input accepted while all stages full and output stalled");

  // An accepted word lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted word missing from stage 1");

  // Stage 3, when it cannot drain, keeps its word
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[2] && !en[3]) |=> vld[2])
    else $error("stage 3 word dropped during stall");
`endif

endmodule

### tb/rep_edge_checker.sv
// Scoreboard for the rectangle edge proximity classifier: predicts edge codes
// from the accepted query words and the limit writes, and compares the results.
// Depends on rep_pkg.
`timescale 1ns / 1ps

module rep_edge_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [7:0] m_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic cfg_wen,
  input  rep_pkg::lim_t cfg_wdata,
  output int unsigned in_flight,
  output int unsigned fail_count
);
  import rep_pkg::*;

  // Shadow of the distance limit and edge codes still owed by the block
  lim_t       limit_shadow;
  logic [3:0] code_q[$];

  // Is a point within lim of an axis-aligned segment? The segment lies on
  // line, spans [e0, e1] in either order; q_perp/q_along are the point.
  function automatic logic near_segment(longint line, longint e0, longint e1,
                                        longint q_perp, longint q_along,
                                        longint lim);
    longint lo;
    longint hi;
    longint perp;
    longint along;
    lo = (e0 <= e1) ? e0 : e1;
    hi = (e0 <= e1) ? e1 : e0;
    perp = (q_perp >= line) ? q_perp - line : line - q_perp;
    if (q_along < lo) begin
      along = lo - q_along;
    end else if (q_along > hi) begin
      along = q_along - hi;
    end else begin
      along = 0;
    end
    // Far off on either axis: out, and keeps the squares small
    if (perp > lim || along > lim) return 1'b0;
    return (perp * perp + along * along) <= lim * lim;
  endfunction

  // Expected edge code of one query word
  function automatic logic [3:0] edge_code_of(logic [((6*COORD_BITS+7)/8)*8-1:0] word,
                                              lim_t lim);
    longint xmin;
    longint ymin;
    longint xmax;
    longint ymax;
    longint qx;
    longint qy;
    logic [3:0] code;
    xmin = $signed(word[0*COORD_BITS +: COORD_BITS]);
    ymin = $signed(word[1*COORD_BITS +: COORD_BITS]);
    xmax = $signed(word[2*COORD_BITS +: COORD_BITS]);
    ymax = $signed(word[3*COORD_BITS +: COORD_BITS]);
    qx   = $signed(word[4*COORD_BITS +: COORD_BITS]);
    qy   = $signed(word[5*COORD_BITS +: COORD_BITS]);
    code = '0;
    code[EDGE_XMIN] = near_segment(xmin, ymin, ymax, qx, qy, longint'(lim));
    code[EDGE_YMIN] = near_segment(ymin, xmin, xmax, qy, qx, longint'(lim));
    code[EDGE_YMAX] = near_segment(ymax, xmin, xmax, qy, qx, longint'(lim));
    code[EDGE_XMAX] = near_segment(xmax, ymin, ymax, qx, qy, longint'(lim));
    return code;
  endfunction

  // Compare results first (no result leaves in the cycle its query is accepted), then predict
  always @(posedge clk) begin
    logic [3:0] want;
    if (rst) begin
      limit_shadow = LIMIT_RESET;
      code_q.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (code_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result word, edge_code %b", $realtime, m_tdata[3:0]);
          fail_count++;
        end else begin
          want = code_q.pop_front();
          if (m_tdata[3:0] !== want) begin
            if (fail_count < 10)
              $display("%0t: edge_code expected %b, got %b", $realtime, want, m_tdata[3:0]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) code_q = {code_q, edge_code_of(s_tdata, limit_shadow)};
      if (cfg_wen) limit_shadow = cfg_wdata;
    end
    in_flight <= code_q.size();
  end

endmodule

### tb/tb_rect_edge_proximity_classifier.sv
// Testbench top for rect_edge_proximity_classifier: drives queries and limit
// writes, stalls the result side, and reports the verdict of rep_edge_checker.
// Depends on rep_pkg, the classifier RTL and rep_edge_checker.
`timescale 1ns / 1ps

module tb_rect_edge_proximity_classifier;
  import rep_pkg::*;

  localparam int unsigned COORD_BITS     = 16;
  localparam int unsigned WORD_BITS      = ((6*COORD_BITS+7)/8)*8;
  localparam int unsigned PIPE_LATENCY   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 180;

  // Query word, rect_x_min in the low bits
  typedef struct packed {
    logic [COORD_BITS-1:0] point_y;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] rect_y_max;
    logic [COORD_BITS-1:0] rect_x_max;
    logic [COORD_BITS-1:0] rect_y_min;
    logic [COORD_BITS-1:0] rect_x_min;
  } query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [WORD_BITS-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_wen = 1'b0;
  lim_t cfg_wdata = '0;

  int unsigned in_flight;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;
  logic no_gaps = 1'b0;

  rect_edge_proximity_classifier #(.COORD_BITS(COORD_BITS)) dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  rep_edge_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_flight(in_flight), .fail_count(fail_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: open stretches, short stalls, now and then a long one
  initial begin
    int open_len;
    int stall_len;
    int pick;
    @(negedge clk);
    forever begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        open_len  = $urandom_range(30, 100);
        stall_len = 0;
      end else begin
        open_len  = $urandom_range(1, 6);
        stall_len = (pick < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      m_tready <= 1'b1;
      repeat (open_len) @(negedge clk);
      if (stall_len > 0) begin
        m_tready <= 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  // Sender gap: mostly none, some short, a few long
  function automatic int gap_len();
    int pick;
    if (no_gaps) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // One query word, held until accepted
  task automatic send(input int xmin, input int ymin, input int xmax, input int ymax,
                      input int px, input int py);
    query_t q;
    int gap;
    q.rect_x_min = COORD_BITS'(xmin);
    q.rect_y_min = COORD_BITS'(ymin);
    q.rect_x_max = COORD_BITS'(xmax);
    q.rect_y_max = COORD_BITS'(ymax);
    q.point_x    = COORD_BITS'(px);
    q.point_y    = COORD_BITS'(py);
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= q;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending and let every owed result come out
  task automatic wait_pipeline_empty();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic set_limit(input lim_t value);
    wait_pipeline_empty();
    cfg_wdata <= value;
    cfg_wen   <= 1'b1;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  // Endpoint a, endpoint b, or somewhere between
  function automatic int span_pick(int a, int b);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case ($urandom_range(0, 2))
      0: return a;
      1: return b;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic int jitter(int m);
    if ($urandom_range(0, 3) == 0) return 0;
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // Random query: mostly points placed near an edge or corner of the rect
  task automatic send_random(input int lim);
    int pick;
    int x0, y0, x1, y1, bx, by, t;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
           int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
           int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768);
    end else if (pick < 25) begin
      send(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
           pick_extreme(), pick_extreme());
    end else begin
      x0 = int'($urandom_range(0, 64000)) - 32000;
      y0 = int'($urandom_range(0, 64000)) - 32000;
      x1 = x0 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 20000) : $urandom_range(0, 200));
      y1 = y0 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 20000) : $urandom_range(0, 200));
      if (x1 > 32767) x1 = 32767;
      if (y1 > 32767) y1 = 32767;
      // degenerate edges: a line or a single point
      if (pick < 35) begin
        case ($urandom_range(0, 2))
          0: x1 = x0;
          1: y1 = y0;
          default: begin
            x1 = x0;
            y1 = y0;
          end
        endcase
      end
      // swapped corners
      if ($urandom_range(0, 4) == 0) begin
        t = x0; x0 = x1; x1 = t;
      end
      if ($urandom_range(0, 4) == 0) begin
        t = y0; y0 = y1; y1 = t;
      end
      if ($urandom_range(0, 1) == 0) begin
        bx = ($urandom_range(0, 1) == 0) ? x0 : x1;
        by = span_pick(y0, y1);
      end else begin
        by = ($urandom_range(0, 1) == 0) ? y0 : y1;
        bx = span_pick(x0, x1);
      end
      send(x0, y0, x1, y1, bx + jitter(lim + 2), by + jitter(lim + 2));
    end
  endtask

  initial begin
    lim_t limits[8];
    int phase;
    limits = '{10'd1023, 10'd0, 10'd1, 10'd5, 10'd0, 10'd512, 10'd1022, 10'd0};
    limits[4] = lim_t'($urandom_range(0, 1023));
    limits[7] = lim_t'($urandom_range(2, 40));

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed, reset limit of 5; rect (0,0)-(100,100) unless noted
    send(0, 0, 100, 100, 0, 50);           // on xmin edge
    send(0, 0, 100, 100, -5, 50);          // exactly at the limit
    send(0, 0, 100, 100, -6, 50);          // one past it
    send(0, 0, 100, 100, -3, -4);          // 3-4-5 past the corner
    send(0, 0, 100, 100, -4, -4);          // corner, just out
    send(0, 0, 100, 100, 50, 105);         // ymax edge
    send(0, 0, 100, 100, 104, 103);        // xmax and ymax near the corner
    send(100, 100, 0, 0, 50, -5);          // swapped corners
    send(10, 10, 10, 10, 13, 14);          // single-point rect
    send(10, 10, 10, 10, 14, 14);
    send(20, -7, 20, 40, 22, 0);           // zero-width rect
    send(-32768, -32768, 32767, 32767, -32768, 0);
    send(-32768, -32768, 32767, 32767, 32767, 32767);
    send(-32768, -32768, -32768, -32768, 32767, 32767);  // huge offsets
    send(32767, 32767, 32767, 32767, -32768, -32768);

    // Zero limit: only points on an edge count
    set_limit(10'd0);
    send(0, 0, 100, 100, 0, 100);
    send(0, 0, 100, 100, 1, 100);
    send(0, 0, 100, 100, -1, 50);

    // Largest limit
    set_limit(10'd1023);
    send(0, 0, 100, 100, -1023, 50);
    send(0, 0, 100, 100, -1024, 50);
    send(0, 0, 100, 100, -723, -723);      // inside on the diagonal
    send(0, 0, 100, 100, -724, -724);      // just out

    // Random phases over several limits
    for (phase = 0; phase < 8; phase++) begin
      set_limit(limits[phase]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_random(int'(limits[phase]));
      end
    end

    wait_pipeline_empty();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
